// ----- design/gfpe_pkg.sv -----
package gfpe_pkg;

  // Field degree and element type
  localparam int FieldDegree = 8;
  typedef logic [FieldDegree-1:0] gf_elem_t;

  // Width of an unreduced carry-less product
  localparam int ProdWidth = 2 * FieldDegree - 1;
  typedef logic [ProdWidth-1:0] gf_prod_t;

  // Low bits of x^8 + x^6 + x^5 + x + 1 after reset
  localparam gf_elem_t FieldPolyReset = gf_elem_t'(8'h63);

  // Multiplicative identity, power of x at the start of a polynomial
  localparam gf_elem_t GfOne = gf_elem_t'(1);

endpackage

// ----- design/gfpe_in_if.sv -----
interface gfpe_in_if;

  logic                valid;
  logic                ready;
  gfpe_pkg::gf_elem_t  point_x;
  gfpe_pkg::gf_elem_t  coefficient;
  logic                last_coeff;

  modport source (output valid, output point_x, output coefficient, output last_coeff,
                  input ready);
  modport sink   (input valid, input point_x, input coefficient, input last_coeff,
                  output ready);

endinterface

// ----- design/gfpe_out_if.sv -----
interface gfpe_out_if;

  logic                valid;
  logic                ready;
  gfpe_pkg::gf_elem_t  poly_value;

  modport source (output valid, output poly_value, input ready);
  modport sink   (input valid, input poly_value, output ready);

endinterface

// ----- design/gfpe_cfg_if.sv -----
interface gfpe_cfg_if;

  logic                valid;
  logic                ready;
  gfpe_pkg::gf_elem_t  field_poly_low;

  modport source (output valid, output field_poly_low, input ready);
  modport sink   (input valid, input field_poly_low, output ready);

endinterface

// ----- design/gfpe_mul.sv -----
module gfpe_mul (
  input  gfpe_pkg::gf_elem_t a_i,
  input  gfpe_pkg::gf_elem_t b_i,
  input  gfpe_pkg::gf_elem_t poly_i,
  output gfpe_pkg::gf_elem_t prod_o
);

  gfpe_pkg::gf_prod_t full_poly;
  gfpe_pkg::gf_prod_t prod;

  // x^8 term is implicit in the polynomial register
  assign full_poly = gfpe_pkg::gf_prod_t'({1'b1, poly_i});

  // Carry-less product, then reduce from the top bit down
  always_comb begin
    prod = '0;
    for (int k = 0; k < gfpe_pkg::FieldDegree; k++) begin
      if (b_i[k]) begin
        prod = prod ^ (gfpe_pkg::gf_prod_t'(a_i) << k);
      end
    end
    for (int k = gfpe_pkg::ProdWidth - 1; k >= gfpe_pkg::FieldDegree; k--) begin
      if (prod[k]) begin
        prod = prod ^ (full_poly << (k - gfpe_pkg::FieldDegree));
      end
    end
  end

  assign prod_o = prod[gfpe_pkg::FieldDegree-1:0];

endmodule

// ----- design/gf256_polynomial_evaluator_unit.sv -----
// Channel     Dir  Payload                                 Handshake
// in_chan_i   in   point_x, coefficient, last_coeff        valid/ready
// res_chan_o  out  poly_value                              valid/ready
// cfg_chan_i  in   field_poly_low                          valid/ready (ready always high)
//
// One coefficient per cycle while the input register drains. Each item is held
// in the input register, which feeds both GF multiplies and the sum/power update.
// On the last coefficient the sum passes from the input register into the result
// register once it is free, and is offered from there. A stalled result only
// blocks a following last item; reset clears the sum to 0, the power to 1 and
// the field polynomial to 0x63.
module gf256_polynomial_evaluator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  gfpe_in_if.sink    in_chan_i,
  gfpe_out_if.source res_chan_o,
  gfpe_cfg_if.sink   cfg_chan_i
);

  // Input register
  logic               in_valid_q;
  gfpe_pkg::gf_elem_t x_q;
  gfpe_pkg::gf_elem_t coeff_q;
  logic               last_q;

  // Accumulator state
  gfpe_pkg::gf_elem_t sum_q, sum_d;
  gfpe_pkg::gf_elem_t power_q, power_d;
  gfpe_pkg::gf_elem_t poly_q;

  // Result register
  logic               res_valid_q;
  gfpe_pkg::gf_elem_t res_value_q;

  gfpe_pkg::gf_elem_t term;
  gfpe_pkg::gf_elem_t next_power;
  logic               res_free;
  logic               advance;
  logic               in_take;

  // Handshake: the input stage drains unless a last item waits on a full output
  assign res_free  = !res_valid_q || res_chan_o.ready;
  assign advance   = in_valid_q && (!last_q || res_free);
  assign in_chan_i.ready = !in_valid_q || advance;
  assign in_take   = in_chan_i.valid && in_chan_i.ready;
  assign cfg_chan_i.ready = 1'b1;

  assign res_chan_o.valid      = res_valid_q;
  assign res_chan_o.poly_value = res_value_q;

  // Coefficient times current power, and power times x
  gfpe_mul u_term_mul (
    .a_i    (coeff_q),
    .b_i    (power_q),
    .poly_i (poly_q),
    .prod_o (term)
  );

  gfpe_mul u_power_mul (
    .a_i    (power_q),
    .b_i    (x_q),
    .poly_i (poly_q),
    .prod_o (next_power)
  );

  assign sum_d   = sum_q ^ term;
  assign power_d = next_power;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      in_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q     <= in_chan_i.point_x;
      coeff_q <= in_chan_i.coefficient;
      last_q  <= in_chan_i.last_coeff;
    end
  end

  // Field polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfpe_pkg::FieldPolyReset;
    end else if (cfg_chan_i.valid) begin
      poly_q <= cfg_chan_i.field_poly_low;
    end
  end

  // Running sum and power; cleared after the last coefficient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      power_q <= gfpe_pkg::GfOne;
    end else if (advance) begin
      if (last_q) begin
        sum_q   <= '0;
        power_q <= gfpe_pkg::GfOne;
      end else begin
        sum_q   <= sum_d;
        power_q <= power_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      res_valid_q <= 1'b1;
    end else if (res_chan_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_value_q <= sum_d;
    end
  end

endmodule

// ----- design/gfpe_checker.sv -----
module gfpe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input gfpe_pkg::gf_elem_t res_value_i,
  input logic               cfg_valid_i,
  input logic               cfg_ready_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_value_i))
    else $error("result changed while stalled");

  // A last item taken behind a stalled result may pass only with the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i && in_valid_i && in_ready_i && in_last_i
    |=> in_ready_i == res_ready_i)
    else $error("input ready ignores pending result");

  // Configuration writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind gf256_polynomial_evaluator_unit gfpe_checker u_gfpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan_i.valid),
  .in_ready_i  (in_chan_i.ready),
  .in_last_i   (in_chan_i.last_coeff),
  .res_valid_i (res_chan_o.valid),
  .res_ready_i (res_chan_o.ready),
  .res_value_i (res_chan_o.poly_value),
  .cfg_valid_i (cfg_chan_i.valid),
  .cfg_ready_i (cfg_chan_i.ready)
);

// ----- tb/gf256_polynomial_evaluator_unit_tb.sv -----
module gf256_polynomial_evaluator_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the running sum and power of x, holds the values the block owes
  class poly_eval_board;
    gfpe_pkg::gf_elem_t    field_low;
    gfpe_pkg::gf_elem_t    sum_acc;
    gfpe_pkg::gf_elem_t    power_acc;
    gfpe_pkg::gf_elem_t    pending_values[$];
    int unsigned           mismatches;

    function new();
      field_low  = gfpe_pkg::FieldPolyReset;
      sum_acc    = '0;
      power_acc  = gfpe_pkg::GfOne;
      mismatches = 0;
    endfunction

    // Shift-and-add product, reducing by x^8 + field_low whenever the top bit shifts out
    function gfpe_pkg::gf_elem_t gf_mult(gfpe_pkg::gf_elem_t a, gfpe_pkg::gf_elem_t b);
      gfpe_pkg::gf_elem_t acc;
      gfpe_pkg::gf_elem_t shifted;
      logic               top;
      acc     = '0;
      shifted = a;
      for (int k = 0; k < gfpe_pkg::FieldDegree; k++) begin
        if (b[k]) acc ^= shifted;
        top     = shifted[gfpe_pkg::FieldDegree-1];
        shifted = {shifted[gfpe_pkg::FieldDegree-2:0], 1'b0};
        if (top) shifted ^= field_low;
      end
      return acc;
    endfunction

    // Accepted coefficient item
    function void note_coeff(gfpe_pkg::gf_elem_t x, gfpe_pkg::gf_elem_t coeff, logic last);
      sum_acc  ^= gf_mult(coeff, power_acc);
      power_acc = gf_mult(power_acc, x);
      if (last) begin
        pending_values.push_back(sum_acc);
        sum_acc   = '0;
        power_acc = gfpe_pkg::GfOne;
      end
    endfunction

    // Accepted result item
    function void check_value(gfpe_pkg::gf_elem_t got);
      gfpe_pkg::gf_elem_t want;
      if (pending_values.size() == 0) begin
        $error("poly_value: expected none, got %02h", got);
        mismatches++;
      end else begin
        want = pending_values.pop_front();
        if (want !== got) begin
          $error("poly_value: expected %02h, got %02h", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  bit   hold_req;

  gfpe_in_if  in_if ();
  gfpe_out_if res_if ();
  gfpe_cfg_if cfg_if ();

  poly_eval_board board = new();

  gf256_polynomial_evaluator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .res_chan_o (res_if),
    .cfg_chan_i (cfg_if)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        stall_left = 300;
        hold_req   = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !idle_on || ($urandom_range(99) >= 38);
      end
    end
  end

  // Watch all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) board.check_value(res_if.poly_value);
      if (in_if.valid && in_if.ready)
        board.note_coeff(in_if.point_x, in_if.coefficient, in_if.last_coeff);
      if (cfg_if.valid && cfg_if.ready) board.field_low = cfg_if.field_poly_low;
    end
  end

  // One coefficient item, with a random gap ahead of it
  task automatic send_coeff(gfpe_pkg::gf_elem_t x, gfpe_pkg::gf_elem_t coeff, logic last);
    if (idle_on && $urandom_range(99) < 38) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.point_x     <= x;
    in_if.coefficient <= coeff;
    in_if.last_coeff  <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop sending and let every owed value come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending_values.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_poly(gfpe_pkg::gf_elem_t low);
    cfg_if.valid          <= 1'b1;
    cfg_if.field_poly_low <= low;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Random polynomials; the phase may end mid-polynomial
  task automatic run_phase(int n_items);
    int                 sent;
    int                 len;
    bit                 vary;
    gfpe_pkg::gf_elem_t x;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      vary = ($urandom_range(9) == 0);
      case ($urandom_range(15))
        0:       x = 8'h00;
        1:       x = 8'h01;
        2:       x = 8'hFF;
        default: x = gfpe_pkg::gf_elem_t'($urandom);
      endcase
      for (int k = 0; k < len && sent < n_items; k++) begin
        if (vary) x = gfpe_pkg::gf_elem_t'($urandom);
        send_coeff(x, gfpe_pkg::gf_elem_t'($urandom), k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.point_x         <= '0;
    in_if.coefficient     <= '0;
    in_if.last_coeff      <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.field_poly_low <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-coefficient polynomials at the field extremes
    send_coeff(8'h00, 8'hFF, 1'b1);
    send_coeff(8'hFF, 8'h00, 1'b1);
    // Short polynomial at x = 2, then all-ones
    send_coeff(8'h02, 8'h01, 1'b0);
    send_coeff(8'h02, 8'h80, 1'b0);
    send_coeff(8'h02, 8'hFF, 1'b0);
    send_coeff(8'h02, 8'h55, 1'b1);
    send_coeff(8'hFF, 8'hFF, 1'b0);
    send_coeff(8'hFF, 8'hFF, 1'b0);
    send_coeff(8'hFF, 8'hFF, 1'b1);
    // Point changes within one polynomial
    send_coeff(8'h03, 8'h12, 1'b0);
    send_coeff(8'hC5, 8'h34, 1'b0);
    send_coeff(8'h80, 8'hAB, 1'b1);
    // Polynomial left open across a field change
    send_coeff(8'h57, 8'hE1, 1'b0);
    send_coeff(8'h9A, 8'h3C, 1'b0);
    drain();
    write_poly(8'h1B);
    send_coeff(8'h0F, 8'h77, 1'b0);
    send_coeff(8'h01, 8'hA5, 1'b1);
    drain();

    // Random phases over several field polynomials, reducible ones included
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       write_poly(8'h00);
        1:       write_poly(8'hFF);
        2:       write_poly(8'h1B);
        3:       write_poly(8'h63);
        4:       write_poly(8'h01);
        default: write_poly(gfpe_pkg::gf_elem_t'($urandom));
      endcase
      idle_on = (phase != 3);
      if (phase == 5) begin
        // Back up the result path until the input stalls
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
          send_coeff(gfpe_pkg::gf_elem_t'($urandom), gfpe_pkg::gf_elem_t'($urandom), 1'b1);
      end
      run_phase(73);
      drain();
    end

    if (board.mismatches == 0 && board.pending_values.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
